// File: src/matrix_multiply_4x4_unit_assert.svh
// assertion macros for the matrix multiply unit
`ifndef MATRIX_MULTIPLY_4X4_UNIT_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// condition must never hold outside reset
`define MM4_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mm4 assertion failed");
// antecedent implies consequent on the following cycle
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mm4 assertion failed");
`else
`define MM4_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/mm4_pkg.sv
`default_nettype none

package mm4_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [31:0] product;
    logic               overflow;
    logic               last;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUTPUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic rd_en;
    logic out_load;
    logic next_elem;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic k_last;
    logic elem_last;
    logic pipe_empty;
  } sts_t;

endpackage

`default_nettype wire

// File: src/mm4_datapath.sv
`default_nettype none

module mm4_datapath #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mm4_pkg::in_item_t  in_data,
  input  mm4_pkg::cmd_t      cmd,
  output mm4_pkg::sts_t      sts,
  output mm4_pkg::out_item_t out_data
);
  import mm4_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int IW    = $clog2(DIM);
  localparam int AW    = $clog2(CELLS);
  localparam int ACC_W = 64 + IW;

  logic [31:0]              first_mem  [CELLS];
  logic [31:0]              second_mem [CELLS];
  logic [CELLS-1:0]         first_vld_r;
  logic [CELLS-1:0]         second_vld_r;
  logic                     wr_ok;
  logic [AW-1:0]            wr_addr;
  logic                     wr_first;
  logic                     wr_second;
  logic [IW-1:0]            k_r;
  logic [IW-1:0]            r_r;
  logic [IW-1:0]            c_r;
  logic                     k_last;
  logic                     r_last;
  logic                     c_last;
  logic [AW-1:0]            rd_a_addr;
  logic [AW-1:0]            rd_b_addr;
  logic [31:0]              rd_first_r;
  logic [31:0]              rd_second_r;
  logic                     rd_first_ok_r;
  logic                     rd_second_ok_r;
  logic                     rd_vld_r;
  logic signed [31:0]       a_op;
  logic signed [31:0]       b_op;
  logic signed [63:0]       mul_r;
  logic                     mul_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-32:0]        hi_bits;
  logic                     fits;
  logic [IW+1:0]            r_wide;
  logic [IW+1:0]            c_wide;
  out_item_t                out_r;

  // load decode
  assign wr_ok     = (int'(in_data.row) < DIM) && (int'(in_data.col) < DIM);
  assign wr_addr   = AW'(int'(in_data.row) * DIM + int'(in_data.col));
  assign wr_first  = cmd.accept && (in_data.op == OP_LOAD_FIRST) && wr_ok;
  assign wr_second = cmd.accept && (in_data.op == OP_LOAD_SECOND) && wr_ok;

  // element storage, written by loads
  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[wr_addr] <= in_data.value;
    end
    if (wr_second) begin
      second_mem[wr_addr] <= in_data.value;
    end
  end

  // written flags, an unwritten element reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_vld_r  <= '0;
      second_vld_r <= '0;
    end else begin
      if (wr_first) begin
        first_vld_r[wr_addr] <= 1'b1;
      end
      if (wr_second) begin
        second_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // row, column and inner index counters
  assign k_last = (k_r == IW'(DIM - 1));
  assign r_last = (r_r == IW'(DIM - 1));
  assign c_last = (c_r == IW'(DIM - 1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      k_r <= '0;
      r_r <= '0;
      c_r <= '0;
    end else begin
      if (cmd.rd_en) begin
        k_r <= k_last ? '0 : k_r + 1'b1;
      end
      if (cmd.next_elem) begin
        if (c_last) begin
          c_r <= '0;
          r_r <= r_r + 1'b1;
        end else begin
          c_r <= c_r + 1'b1;
        end
      end
    end
  end

  // operand reads
  assign rd_a_addr = AW'(int'(r_r) * DIM + int'(k_r));
  assign rd_b_addr = AW'(int'(k_r) * DIM + int'(c_r));

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_first_r     <= first_mem[rd_a_addr];
      rd_second_r    <= second_mem[rd_b_addr];
      rd_first_ok_r  <= first_vld_r[rd_a_addr];
      rd_second_ok_r <= second_vld_r[rd_b_addr];
    end
  end

  // multiply stage
  assign a_op = rd_first_ok_r ? signed'(rd_first_r) : '0;
  assign b_op = rd_second_ok_r ? signed'(rd_second_r) : '0;

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      mul_r <= a_op * b_op;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.rd_en;
      mul_vld_r <= rd_vld_r;
    end
  end

  // accumulate, cleared as each element starts
  always_ff @(posedge clk) begin
    if (cmd.rd_en && (k_r == '0)) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + ACC_W'(mul_r);
    end
  end

  // scale down and saturate
  assign shifted = acc_r >>> FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:31];
  assign fits    = (&hi_bits) || !(|hi_bits);
  assign r_wide  = {2'b00, r_r};
  assign c_wide  = {2'b00, c_r};

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.out_row  <= r_wide[1:0];
      out_r.out_col  <= c_wide[1:0];
      out_r.overflow <= !fits;
      out_r.last     <= r_last && c_last;
      if (fits) begin
        out_r.product <= shifted[31:0];
      end else if (acc_r[ACC_W-1]) begin
        out_r.product <= 32'sh8000_0000;
      end else begin
        out_r.product <= 32'sh7fff_ffff;
      end
    end
  end

  assign out_data       = out_r;
  assign sts.k_last     = k_last;
  assign sts.elem_last  = r_last && c_last;
  assign sts.pipe_empty = !rd_vld_r && !mul_vld_r;

endmodule

`default_nettype wire

// File: src/mm4_ctrl.sv
`default_nettype none

module mm4_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mm4_pkg::sts_t sts,
  output mm4_pkg::cmd_t cmd
);
  import mm4_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_COMPUTE) begin
            cmd.start = 1'b1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        if (sts.k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.elem_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_elem = 1'b1;
            state_nxt     = ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/matrix_multiply_4x4_unit.sv
// Square matrix multiplier for signed fixed-point elements (FRAC_BITS fraction bits).
// Op 0 and op 1 beats write one element of the first or second matrix; op 3 beats
// and out-of-range indexes are dropped. An op 2 beat emits all DIM*DIM product
// elements in row-major order, each the exact sum of DIM products shifted right
// with floor rounding and saturated to 32 bits, with overflow marking saturation
// and last marking the final element. One shared 32x32 multiplier and accumulator
// serve every element: each one takes DIM operand reads through the read, multiply
// and accumulate registers, is then scaled and saturated into the result register,
// and is offered on the output before the next element starts.
// No new input beat is taken until the last result of a compute has been delivered.
// Both matrices read as zero after reset until written.
`default_nettype none
`include "matrix_multiply_4x4_unit_assert.svh"

module matrix_multiply_4x4_unit #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mm4_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mm4_pkg::out_item_t out_data
);
  import mm4_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  mm4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, multiply-accumulate and result register
  mm4_datapath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // checks
  `MM4_ASSERT_NEVER(a_in_out_exclusive, clk, rst_n, in_ready && out_valid)
  `MM4_ASSERT_NEXT(a_idle_after_last, clk, rst_n, out_valid && out_ready && out_data.last, in_ready)
  `MM4_ASSERT_NEXT(a_busy_after_compute, clk, rst_n, in_valid && in_ready && (in_data.op == OP_COMPUTE), !in_ready)
  `MM4_ASSERT_NEXT(a_gap_between_results, clk, rst_n, out_valid && out_ready && !out_data.last, !out_valid && !in_ready)

endmodule

`default_nettype wire

// File: bench/tb_matrix_multiply_4x4_unit.sv
`default_nettype none

module tb_matrix_multiply_4x4_unit;
  import mm4_pkg::*;

  localparam int DIM  = 4;
  localparam int FRAC = 16;

  // op code the block drops
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // element values used by the directed rows
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_NEG_LSB = -32'sd1;

  // saturation bounds of the wide sum
  localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  matrix_multiply_4x4_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // local copy of both operand matrices, row-major
  logic signed [31:0] mat_a [DIM*DIM];
  logic signed [31:0] mat_b [DIM*DIM];

  out_item_t products_due [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int beats_checked  = 0;
  int saturated_seen = 0;
  int loads_sent     = 0;
  int computes_sent  = 0;
  int ignored_sent   = 0;

  // run limit
  initial begin
    #12_000_000;
    $display("timeout with %0d product beats still due", products_due.size());
    $display("FAIL matrix_multiply_4x4_unit");
    $finish;
  end

  // directed stimulus row; known rows carry the product of cell (0,0), all other cells zero
  typedef struct {
    in_item_t           beat;
    bit                 known;
    logic signed [31:0] cell0;
    bit                 cell0_ovf;
  } step_t;

  step_t script [$];

  function automatic void add_step(logic [1:0] op, logic [1:0] r, logic [1:0] c,
                                   logic signed [31:0] v, bit known = 1'b0,
                                   logic signed [31:0] p = '0, bit ovf = 1'b0);
    step_t s;
    s.beat.op    = op;
    s.beat.row   = r;
    s.beat.col   = c;
    s.beat.value = v;
    s.known      = known;
    s.cell0      = p;
    s.cell0_ovf  = ovf;
    script.push_back(s);
  endfunction

  // one product cell: exact dot product, floor shift, saturate
  function automatic out_item_t product_cell(int r, int c);
    logic signed [65:0] acc;
    logic signed [65:0] a;
    logic signed [65:0] b;
    logic signed [65:0] shifted;
    out_item_t o;
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      a = mat_a[r*DIM + k];
      b = mat_b[k*DIM + c];
      acc = acc + a * b;
    end
    shifted = acc >>> FRAC;
    o.out_row = 2'(r);
    o.out_col = 2'(c);
    o.last    = (r == DIM-1) && (c == DIM-1);
    if (shifted > SUM_MAX) begin
      o.product  = Q_MAX;
      o.overflow = 1'b1;
    end else if (shifted < SUM_MIN) begin
      o.product  = Q_MIN;
      o.overflow = 1'b1;
    end else begin
      o.product  = shifted[31:0];
      o.overflow = 1'b0;
    end
    return o;
  endfunction

  // update the matrices or queue the sixteen products of an accepted beat
  function automatic void track_beat(in_item_t beat);
    case (beat.op)
      OP_LOAD_FIRST: begin
        mat_a[{beat.row, beat.col}] = beat.value;
        loads_sent++;
      end
      OP_LOAD_SECOND: begin
        mat_b[{beat.row, beat.col}] = beat.value;
        loads_sent++;
      end
      OP_COMPUTE: begin
        for (int r = 0; r < DIM; r++)
          for (int c = 0; c < DIM; c++)
            products_due.push_back(product_cell(r, c));
        computes_sent++;
      end
      default: ignored_sent++;
    endcase
  endfunction

  // typed-in products: cell (0,0) as given, all else zero
  function automatic void queue_known(logic signed [31:0] p, bit ovf);
    out_item_t o;
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < DIM; c++) begin
        o.out_row  = 2'(r);
        o.out_col  = 2'(c);
        o.product  = (r == 0 && c == 0) ? p : '0;
        o.overflow = (r == 0 && c == 0) ? ovf : 1'b0;
        o.last     = (r == DIM-1) && (c == DIM-1);
        products_due.push_back(o);
      end
    computes_sent++;
  endfunction

  // element values: extremes, one, small signed, full range
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return $urandom_range(1) ? Q_ONE : -Q_ONE;
      3, 4, 5, 6: return $signed(32'($urandom_range(524288))) - 32'sd262144;
      default: return $urandom;
    endcase
  endfunction

  // mostly loads into random cells, a compute now and then, a little noise
  function automatic in_item_t random_beat();
    in_item_t b;
    int pick;
    pick    = $urandom_range(99);
    b.row   = 2'($urandom_range(3));
    b.col   = 2'($urandom_range(3));
    b.value = pick_value();
    if (pick < 9)       b.op = OP_COMPUTE;
    else if (pick < 14) b.op = OP_UNUSED;
    else if (pick < 57) b.op = OP_LOAD_FIRST;
    else                b.op = OP_LOAD_SECOND;
    return b;
  endfunction

  // present one beat after a random gap, return at the accepting edge
  task automatic drive_beat(input in_item_t beat);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender holds off until every due product has arrived
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (products_due.size() != 0);
  endtask

  task automatic note_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): expected row %0d col %0d product %h ovf %0b last %0b,",
                " got row %0d col %0d product %h ovf %0b last %0b"},
               what, want.out_row, want.out_col, want.product, want.overflow, want.last,
               got.out_row, got.out_col, got.product, got.overflow, got.last);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checking
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (products_due.size() == 0) begin
        note_mismatch("nothing due", '0, out_data);
      end else begin
        want = products_due.pop_front();
        if (out_data.out_row !== want.out_row || out_data.out_col !== want.out_col ||
            out_data.product !== want.product || out_data.overflow !== want.overflow ||
            out_data.last !== want.last)
          note_mismatch("field", want, out_data);
        if (out_data.overflow === 1'b1) saturated_seen++;
      end
      beats_checked++;
    end
  end

  // stimulus
  initial begin
    in_item_t beat;
    int counted;

    for (int i = 0; i < DIM*DIM; i++) begin
      mat_a[i] = '0;
      mat_b[i] = '0;
    end

    // products straight after reset
    add_step(OP_COMPUTE, 2'd0, 2'd0, '0, 1'b1, '0, 1'b0);
    // most negative squared saturates high
    add_step(OP_LOAD_FIRST, 2'd0, 2'd0, Q_MIN);
    add_step(OP_LOAD_SECOND, 2'd0, 2'd0, Q_MIN);
    add_step(OP_COMPUTE, 2'd3, 2'd3, Q_MAX, 1'b1, Q_MAX, 1'b1);
    // max times min saturates low
    add_step(OP_LOAD_FIRST, 2'd0, 2'd0, Q_MAX);
    add_step(OP_COMPUTE, 2'd0, 2'd0, '0, 1'b1, Q_MIN, 1'b1);
    // max times one sits exactly on the upper bound
    add_step(OP_LOAD_SECOND, 2'd0, 2'd0, Q_ONE);
    add_step(OP_COMPUTE, 2'd0, 2'd0, '0, 1'b1, Q_MAX, 1'b0);
    // min times one sits exactly on the lower bound
    add_step(OP_LOAD_FIRST, 2'd0, 2'd0, Q_MIN);
    add_step(OP_COMPUTE, 2'd0, 2'd0, '0, 1'b1, Q_MIN, 1'b0);
    // minus one lsb times one
    add_step(OP_LOAD_FIRST, 2'd0, 2'd0, Q_NEG_LSB);
    add_step(OP_COMPUTE, 2'd0, 2'd0, '0, 1'b1, Q_NEG_LSB, 1'b0);
    // tiny negative product floors to minus one lsb
    add_step(OP_LOAD_SECOND, 2'd0, 2'd0, 32'sd1);
    add_step(OP_COMPUTE, 2'd0, 2'd0, '0, 1'b1, Q_NEG_LSB, 1'b0);
    // unused op must not touch cell (0,0)
    add_step(OP_UNUSED, 2'd0, 2'd0, '0);
    add_step(OP_COMPUTE, 2'd1, 2'd2, '0, 1'b1, Q_NEG_LSB, 1'b0);
    // far corner and mixed cells, predicted
    add_step(OP_LOAD_FIRST, 2'd3, 2'd3, 32'sh0003_0000);
    add_step(OP_LOAD_SECOND, 2'd3, 2'd3, 32'shfffe_0000);
    add_step(OP_LOAD_FIRST, 2'd3, 2'd0, Q_MAX);
    add_step(OP_LOAD_SECOND, 2'd0, 2'd3, Q_MAX);
    add_step(OP_UNUSED, 2'd3, 2'd3, Q_NEG_LSB);
    add_step(OP_COMPUTE, 2'd0, 2'd0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (script[i]) begin
      drive_beat(script[i].beat);
      if (script[i].known) queue_known(script[i].cell0, script[i].cell0_ovf);
      else track_beat(script[i].beat);
    end
    hold_until_drained();

    // random phases with different idling
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      counted = 0;
      while (counted < 80) begin
        beat = random_beat();
        drive_beat(beat);
        track_beat(beat);
        if (beat.op != OP_UNUSED) counted++;
      end
      hold_until_drained();
    end

    repeat (20) @(posedge clk);

    $display("sent %0d loads, %0d computes and %0d unused-op beats over four idling phases",
             loads_sent, computes_sent, ignored_sent);
    $display("checked %0d product beats, %0d of them saturated, %0d mismatches",
             beats_checked, saturated_seen, mismatches);
    if (mismatches == 0 && products_due.size() == 0) begin
      $display("PASS matrix_multiply_4x4_unit");
    end else begin
      $display("FAIL matrix_multiply_4x4_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+src
src/mm4_pkg.sv
src/mm4_datapath.sv
src/mm4_ctrl.sv
src/matrix_multiply_4x4_unit.sv
bench/tb_matrix_multiply_4x4_unit.sv
